// ===== hw/rtl/utf8_strict_decoder_macros.svh =====
// Assertion macros for the strict UTF-8 decoder.
// Included by the top level; no other dependencies.
`ifndef UTF8_STRICT_DECODER_MACROS_SVH
`define UTF8_STRICT_DECODER_MACROS_SVH

// same-cycle implication
`define U8SD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8sd: same-cycle check failed");

// next-cycle implication
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8sd: next-cycle check failed");

`endif

// ===== hw/rtl/u8sd_pkg.sv =====
// Shared types and constants of the strict UTF-8 decoder.
// Used by the front, queue, back and top-level modules.
package u8sd_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int OUT_OFFSET_BITS     = 32;
   localparam int CODE_BITS           = 21;

   localparam logic [2:0] ERR_TRUNC  = 3'd0;
   localparam logic [2:0] ERR_NOCONT = 3'd1;
   localparam logic [2:0] ERR_OVER3  = 3'd2;
   localparam logic [2:0] ERR_SURR   = 3'd3;
   localparam logic [2:0] ERR_OVER4  = 3'd4;
   localparam logic [2:0] ERR_ABOVE  = 3'd5;
   localparam logic [2:0] ERR_STRAY  = 3'd6;
   localparam logic [2:0] ERR_LEAD   = 3'd7;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_LO   = 8'hC2;
   localparam logic [7:0] LEAD2_HI   = 8'hDF;
   localparam logic [7:0] LEAD3_LO   = 8'hE0;
   localparam logic [7:0] LEAD3_HI   = 8'hEF;
   localparam logic [7:0] LEAD_SURR  = 8'hED;
   localparam logic [7:0] LEAD4_LO   = 8'hF0;
   localparam logic [7:0] LEAD4_HI   = 8'hF4;
   localparam logic [7:0] SEC_E0_MIN = 8'hA0;
   localparam logic [7:0] SEC_ED_MAX = 8'h9F;
   localparam logic [7:0] SEC_F_EDGE = 8'h90;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD
   } byte_class_type;

   typedef struct packed {
      logic [7:0]                 data_byte;
      logic                       final_byte;
      logic [OUT_OFFSET_BITS-1:0] offset;
      byte_class_type             cls;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hw/rtl/u8sd_front.sv =====
// Front end: byte offset counter and byte classification.
// Depends on u8sd_pkg; feeds u8sd_queue.
module u8sd_front
   import u8sd_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        final_byte,
   output q_entry_type entry
);

   logic [OFFSET_BITS-1:0]     count_ff, count_in;
   logic [OUT_OFFSET_BITS-1:0] offset_sat;
   byte_class_type             cls;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (final_byte) begin
            count_in = '0;
         end else if (count_ff != {OFFSET_BITS{1'b1}}) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   generate
      if (OFFSET_BITS > OUT_OFFSET_BITS) begin : g_sat
         always_comb begin
            if (count_ff[OFFSET_BITS-1:OUT_OFFSET_BITS] != '0) begin
               offset_sat = {OUT_OFFSET_BITS{1'b1}};
            end else begin
               offset_sat = count_ff[OUT_OFFSET_BITS-1:0];
            end
         end
      end else begin : g_ext
         assign offset_sat = OUT_OFFSET_BITS'(count_ff);
      end
   endgenerate

   always_comb begin
      if (data_byte < CONT_TAG) begin
         cls = CLS_ASCII;
      end else if ((data_byte & CONT_MASK) == CONT_TAG) begin
         cls = CLS_CONT;
      end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
         cls = CLS_LEAD2;
      end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
         cls = CLS_LEAD3;
      end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
         cls = CLS_LEAD4;
      end else begin
         cls = CLS_BAD;
      end
   end

   always_comb begin
      entry.data_byte  = data_byte;
      entry.final_byte = final_byte;
      entry.offset     = offset_sat;
      entry.cls        = cls;
   end

endmodule

// ===== hw/rtl/u8sd_queue.sv =====
// Short FIFO of classified bytes between front and back.
// Depends on u8sd_pkg.
module u8sd_queue
   import u8sd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   input  logic        pop,
   output q_entry_type pop_entry,
   output q_stat_type  stat,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   q_entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == CNT_FULL);
   assign stat.empty = (cnt_ff == '0);
   assign count      = cnt_ff;

endmodule

// ===== hw/rtl/u8sd_back.sv =====
// Back end: sequence decoding, error holding and the result register.
// Depends on u8sd_pkg; drains u8sd_queue.
module u8sd_back
   import u8sd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  q_stat_type                 q_stat,
   input  q_entry_type                item,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [CODE_BITS-1:0]       out_code_point,
   output logic [OUT_OFFSET_BITS-1:0] out_start_offset,
   output logic                       out_error_flag,
   output logic [2:0]                 out_error_kind,
   output logic                       out_text_end
);

   logic [OUT_OFFSET_BITS-1:0] seq_start_ff, seq_start_in;
   logic [CODE_BITS-1:0]       partial_ff, partial_in;
   logic [1:0]                 need_ff, need_in;
   logic                       second_ff, second_in;
   logic [7:0]                 lead_ff, lead_in;
   logic                       held_ff, held_in;
   logic [2:0]                 held_kind_ff, held_kind_in;
   logic                       discard_ff, discard_in;

   logic                       res_valid;
   logic [CODE_BITS-1:0]       res_cp;
   logic [OUT_OFFSET_BITS-1:0] res_off;
   logic                       res_err;
   logic [2:0]                 res_kind;

   logic                       valid_ff;
   logic [CODE_BITS-1:0]       cp_ff;
   logic [OUT_OFFSET_BITS-1:0] off_ff;
   logic                       err_ff;
   logic [2:0]                 kind_ff;
   logic                       end_ff;

   logic [7:0]                 b;
   logic [1:0]                 need_dec;

   assign pop      = !q_stat.empty && (!valid_ff || out_ready);
   assign b        = item.data_byte;
   assign need_dec = need_ff - 2'd1;

   always_comb begin
      seq_start_in = seq_start_ff;
      partial_in   = partial_ff;
      need_in      = need_ff;
      second_in    = second_ff;
      lead_in      = lead_ff;
      held_in      = held_ff;
      held_kind_in = held_kind_ff;
      discard_in   = discard_ff;
      res_valid    = 1'b0;
      res_cp       = '0;
      res_off      = item.offset;
      res_err      = 1'b0;
      res_kind     = ERR_TRUNC;
      if (pop) begin
         if (discard_ff) begin
            res_valid = 1'b0;
         end else if (need_ff == 2'd0) begin
            unique case (item.cls)
               CLS_ASCII: begin
                  res_valid = 1'b1;
                  res_cp    = CODE_BITS'(b);
               end
               CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                  seq_start_in = item.offset;
                  lead_in      = b;
                  second_in    = 1'b1;
                  held_in      = 1'b0;
                  if (item.cls == CLS_LEAD2) begin
                     need_in    = 2'd1;
                     partial_in = CODE_BITS'(b[4:0]);
                  end else if (item.cls == CLS_LEAD3) begin
                     need_in    = 2'd2;
                     partial_in = CODE_BITS'(b[3:0]);
                  end else begin
                     need_in    = 2'd3;
                     partial_in = CODE_BITS'(b[2:0]);
                  end
                  if (item.final_byte) begin
                     res_valid = 1'b1;
                     res_err   = 1'b1;
                     res_kind  = ERR_TRUNC;
                  end
               end
               CLS_CONT: begin
                  res_valid  = 1'b1;
                  res_err    = 1'b1;
                  res_kind   = ERR_STRAY;
                  discard_in = 1'b1;
               end
               default: begin
                  res_valid  = 1'b1;
                  res_err    = 1'b1;
                  res_kind   = ERR_LEAD;
                  discard_in = 1'b1;
               end
            endcase
         end else begin
            if (item.cls != CLS_CONT) begin
               held_in      = 1'b1;
               held_kind_in = ERR_NOCONT;
            end else if (second_ff && !held_ff) begin
               if (lead_ff == LEAD3_LO && b < SEC_E0_MIN) begin
                  held_in      = 1'b1;
                  held_kind_in = ERR_OVER3;
               end else if (lead_ff == LEAD_SURR && b > SEC_ED_MAX) begin
                  held_in      = 1'b1;
                  held_kind_in = ERR_SURR;
               end else if (lead_ff == LEAD4_LO && b < SEC_F_EDGE) begin
                  held_in      = 1'b1;
                  held_kind_in = ERR_OVER4;
               end else if (lead_ff == LEAD4_HI && b >= SEC_F_EDGE) begin
                  held_in      = 1'b1;
                  held_kind_in = ERR_ABOVE;
               end
            end
            second_in  = 1'b0;
            partial_in = {partial_ff[CODE_BITS-7:0], b[5:0]};
            need_in    = need_dec;
            res_off    = seq_start_ff;
            if (need_dec == 2'd0) begin
               res_valid = 1'b1;
               if (held_in) begin
                  res_err    = 1'b1;
                  res_kind   = held_kind_in;
                  discard_in = 1'b1;
               end else begin
                  res_cp = partial_in;
               end
            end else if (item.final_byte) begin
               res_valid = 1'b1;
               res_err   = 1'b1;
               res_kind  = ERR_TRUNC;
            end
         end
         if (item.final_byte) begin
            seq_start_in = '0;
            partial_in   = '0;
            need_in      = 2'd0;
            second_in    = 1'b0;
            lead_in      = '0;
            held_in      = 1'b0;
            held_kind_in = ERR_TRUNC;
            discard_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_start_ff <= '0;
         partial_ff   <= '0;
         need_ff      <= 2'd0;
         second_ff    <= 1'b0;
         lead_ff      <= '0;
         held_ff      <= 1'b0;
         held_kind_ff <= ERR_TRUNC;
         discard_ff   <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         seq_start_ff <= seq_start_in;
         partial_ff   <= partial_in;
         need_ff      <= need_in;
         second_ff    <= second_in;
         lead_ff      <= lead_in;
         held_ff      <= held_in;
         held_kind_ff <= held_kind_in;
         discard_ff   <= discard_in;
         if (pop && res_valid) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // load result payload on transfer into the output register
   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         cp_ff   <= res_cp;
         off_ff  <= res_off;
         err_ff  <= res_err;
         kind_ff <= res_kind;
         end_ff  <= item.final_byte;
      end
   end

   assign out_valid        = valid_ff;
   assign out_code_point   = cp_ff;
   assign out_start_offset = off_ff;
   assign out_error_flag   = err_ff;
   assign out_error_kind   = kind_ff;
   assign out_text_end     = end_ff;

endmodule

// ===== hw/rtl/utf8_strict_decoder.sv =====
// Top level of the strict UTF-8 decoder: front, queue and back end.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back and the macro header.
//
//   channel  dir  handshake           payload
//   req      in   req_tvalid/tready   tdata = data_byte, tlast = final_byte
//   rsp      out  rsp_tvalid/tready   tdata = code_point, start_offset;
//                                     tuser = error_flag, error_kind; tlast = text_end
//
// One byte per cycle sustained while the queue is not full; rsp_tvalid rises
// after its byte has passed the queue entry and then the output register.
// The queue holds QUEUE_DEPTH bytes; req_tready drops only when it is full.
// Reset is synchronous; the offset counter and all decode state clear,
// and also clear after every final byte.
`include "utf8_strict_decoder_macros.svh"

module utf8_strict_decoder
   import u8sd_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [20:0] code_point, [52:21] start_offset, rest zero
   output logic [3:0]  rsp_tuser,   // [0] error_flag, [3:1] error_kind
   output logic        rsp_tlast
);

   q_entry_type                     push_entry;
   q_entry_type                     pop_entry;
   q_stat_type                      q_stat;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic                            push;
   logic                            pop;
   logic [CODE_BITS-1:0]            cp;
   logic [OUT_OFFSET_BITS-1:0]      off;
   logic                            err;
   logic [2:0]                      kind;

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   u8sd_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (push),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .entry      (push_entry)
   );

   u8sd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .stat       (q_stat),
      .count      (q_count)
   );

   u8sd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .item             (pop_entry),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_code_point   (cp),
      .out_start_offset (off),
      .out_error_flag   (err),
      .out_error_kind   (kind),
      .out_text_end     (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, off, cp};
   assign rsp_tuser = {kind, err};

   `U8SD_ASSERT_IMPL(a_err_zero_cp, clock, reset, rsp_tvalid && err, cp == '0)
   `U8SD_ASSERT_IMPL(a_cp_scalar, clock, reset, rsp_tvalid && !err,
      cp <= 21'h10FFFF && !(cp >= 21'h00D800 && cp <= 21'h00DFFF))
   `U8SD_ASSERT_IMPL(a_trunc_at_end, clock, reset,
      rsp_tvalid && err && kind == ERR_TRUNC, rsp_tlast)
   `U8SD_ASSERT_NEXT(a_queue_fill, clock, reset, push && !pop,
      q_count == $past(q_count) + 1'b1)

endmodule

// ===== tb/utf8_strict_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for utf8_strict_decoder: byte streams in, code points out.
// Predicts every result with its own strict decoder and checks each transfer in order.
// Depends on u8sd_pkg and the utf8_strict_decoder RTL only.
module utf8_strict_decoder_test;
   import u8sd_pkg::*;

   localparam int TEXT_BYTES  = 850;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic [20:0] code_point;
      logic [31:0] start_offset;
      logic        error_flag;
      logic [2:0]  error_kind;
      logic        text_end;
   } decoded_item_type;

   class decode_tracker;
      decoded_item_type pending[$];
      int            errors;
      logic [31:0]   offset_count;
      logic [31:0]   seq_start;
      logic [20:0]   partial;
      logic [1:0]    need;
      logic          second_due;
      logic [7:0]    lead;
      logic          held_valid;
      logic [2:0]    held_kind;
      logic          dropping;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         offset_count = '0;
         seq_start    = '0;
         partial      = '0;
         need         = '0;
         second_due   = 1'b0;
         lead         = '0;
         held_valid   = 1'b0;
         held_kind    = '0;
         dropping     = 1'b0;
      endfunction

      function bit is_cont(logic [7:0] b);
         return (b & CONT_MASK) == CONT_TAG;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      // returns 1 when the byte was decoded rather than dropped
      function bit take_byte(logic [7:0] b, logic fin);
         logic [31:0]   at;
         logic [1:0]    width;
         logic [7:0]    mask;
         decoded_item_type r;
         bit            emit;
         at    = offset_count;
         width = '0;
         mask  = '0;
         r     = '0;
         emit  = 1'b0;
         if (offset_count != '1) offset_count++;
         if (dropping) begin
            if (fin) clear();
            return 1'b0;
         end
         if (need == 0) begin
            if (b < 8'h80) begin
               r.code_point   = 21'(b);
               r.start_offset = at;
               emit           = 1'b1;
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
               width = 2'd1;
               mask  = 8'h1F;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
               width = 2'd2;
               mask  = 8'h0F;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
               width = 2'd3;
               mask  = 8'h07;
            end else begin
               r.start_offset = at;
               r.error_flag   = 1'b1;
               r.error_kind   = is_cont(b) ? ERR_STRAY : ERR_LEAD;
               emit           = 1'b1;
               dropping       = 1'b1;
            end
            if (width != 0) begin
               seq_start  = at;
               lead       = b;
               partial    = 21'(b & mask);
               need       = width;
               second_due = 1'b1;
               held_valid = 1'b0;
               if (fin) begin
                  r.start_offset = at;
                  r.error_flag   = 1'b1;
                  r.error_kind   = ERR_TRUNC;
                  emit           = 1'b1;
               end
            end
         end else begin
            if (!is_cont(b)) begin
               held_valid = 1'b1;
               held_kind  = ERR_NOCONT;
            end else if (second_due && !held_valid) begin
               held_valid = 1'b1;
               if (lead == LEAD3_LO && b < SEC_E0_MIN) held_kind = ERR_OVER3;
               else if (lead == LEAD_SURR && b > SEC_ED_MAX) held_kind = ERR_SURR;
               else if (lead == LEAD4_LO && b < SEC_F_EDGE) held_kind = ERR_OVER4;
               else if (lead == LEAD4_HI && b >= SEC_F_EDGE) held_kind = ERR_ABOVE;
               else held_valid = 1'b0;
            end
            second_due = 1'b0;
            partial    = {partial[14:0], b[5:0]};
            need--;
            if (need == 0) begin
               r.start_offset = seq_start;
               emit           = 1'b1;
               if (held_valid) begin
                  r.error_flag = 1'b1;
                  r.error_kind = held_kind;
                  dropping     = 1'b1;
               end else begin
                  r.code_point = partial;
               end
            end else if (fin) begin
               r.start_offset = seq_start;
               r.error_flag   = 1'b1;
               r.error_kind   = ERR_TRUNC;
               emit           = 1'b1;
            end
         end
         r.text_end = fin;
         if (emit) pending = {pending, r};
         if (fin) clear();
         return 1'b1;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [55:0] tdata, logic [3:0] tuser, logic tlast);
         decoded_item_type want;
         if (pending.size() == 0) begin
            $error("result transfer with none expected: tdata 'h%0h tuser 'h%0h",
                   tdata, tuser);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("code_point", 32'(want.code_point), 32'(tdata[20:0]));
         compare_field("start_offset", want.start_offset, tdata[52:21]);
         compare_field("error_flag", 32'(want.error_flag), 32'(tuser[0]));
         compare_field("error_kind", 32'(want.error_kind), 32'(tuser[3:1]));
         compare_field("text_end", 32'(want.text_end), 32'(tlast));
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   decode_tracker tracker = new();
   logic [7:0]    text_bytes[$];
   int            live_bytes  = 0;
   int            cycles      = 0;
   int            hold_asks   = 0;
   int            holds_done  = 0;
   int            hold_left   = 0;
   bit            tx_idle_on  = 1'b1;
   bit            rx_idle_on  = 1'b1;

   utf8_strict_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold_left  = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= rx_idle_on ? ($urandom_range(99) >= 37) : 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (tx_idle_on) begin
         while ($urandom_range(99) < 37) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      void'(tracker.take_byte(b, fin));
      live_bytes++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   function automatic int lead_need(logic [7:0] b);
      if (b >= LEAD4_LO) return 3;
      if (b >= LEAD3_LO) return 2;
      return 1;
   endfunction

   function automatic void add_byte(logic [7:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   function automatic void add_cont();
      add_byte({2'b10, 6'($urandom_range(63))});
   endfunction

   function automatic void add_scalar();
      logic [20:0] cp;
      case ($urandom_range(3))
         0: begin
            cp = 21'($urandom_range(8'h7F));
            add_byte({1'b0, cp[6:0]});
         end
         1: begin
            cp = 21'($urandom_range(11'h7FF, 11'h080));
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         2: begin
            cp = 21'($urandom_range(16'hFFFF, 16'h0800));
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp ^= 21'h2000;
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // leads whose second byte has a narrowed range
   function automatic void add_edge_lead();
      logic [7:0] b;
      case ($urandom_range(3))
         0:       b = LEAD3_LO;
         1:       b = LEAD_SURR;
         2:       b = LEAD4_LO;
         default: b = LEAD4_HI;
      endcase
      add_byte(b);
      repeat (lead_need(b)) add_cont();
   endfunction

   function automatic void add_broken();
      logic [7:0] b;
      logic [7:0] bad;
      int         n;
      int         brk;
      b   = 8'($urandom_range(LEAD4_HI, LEAD2_LO));
      n   = lead_need(b);
      brk = $urandom_range(n - 1);
      add_byte(b);
      for (int i = 0; i < n; i++) begin
         if (i == brk) begin
            bad = 8'($urandom_range(255));
            if ((bad & CONT_MASK) == CONT_TAG) bad[6] = 1'b1;
            add_byte(bad);
         end else begin
            add_cont();
         end
      end
   endfunction

   function automatic void add_truncated();
      logic [7:0] b;
      b = 8'($urandom_range(LEAD4_HI, LEAD2_LO));
      add_byte(b);
      repeat ($urandom_range(lead_need(b) - 1)) add_cont();
   endfunction

   function automatic void build_text();
      int pick;
      text_bytes.delete();
      repeat ($urandom_range(10, 1)) begin
         pick = $urandom_range(99);
         if (pick < 68) add_scalar();
         else if (pick < 80) add_edge_lead();
         else if (pick < 88) add_broken();
         else add_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0) add_truncated();
   endfunction

   initial begin
      bit held;
      bit paused;
      held   = 1'b0;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // both ends of the one-byte range, and the largest two-byte and four-byte sequences
      text_bytes = {8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      // stray continuation, then drop until the text ends
      text_bytes = {8'h80, 8'h41, 8'hFF};
      send_text();
      text_bytes = {8'hC0};
      send_text();
      text_bytes = {8'hE0, 8'h9F, 8'h80};
      send_text();
      text_bytes = {8'hED, 8'hA0, 8'h80};
      send_text();
      text_bytes = {8'hF0, 8'h8F, 8'h80, 8'h80};
      send_text();
      text_bytes = {8'hF4, 8'h90, 8'h80, 8'h80};
      send_text();
      // missing continuation replaces the held second-byte error
      text_bytes = {8'hE0, 8'h80, 8'h41};
      send_text();
      // truncated mid-sequence, and a lead that is itself the final byte
      text_bytes = {8'hE1, 8'h80};
      send_text();
      text_bytes = {8'hF1};
      send_text();
      drain_results();

      while (live_bytes < TEXT_BYTES) begin
         tx_idle_on = !(live_bytes >= 250 && live_bytes < 450);
         rx_idle_on = !(live_bytes >= 500 && live_bytes < 650);
         if (live_bytes >= 300 && !held) begin
            held = 1'b1;
            hold_asks++;
         end
         if (live_bytes >= 600 && !paused) begin
            paused = 1'b1;
            drain_results();
         end
         build_text();
         send_text();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
